### design/kdsl_pkg.sv
// shared types, constants and key code lookup for the key debounce block
`timescale 1ns / 1ps

package kdsl_pkg;

    localparam int MAP_ENTRIES = 12;
    localparam int TABLE_DEPTH = 16;

    localparam logic [7:0]  NO_KEY          = 8'hFF;
    localparam logic [15:0] HOLD_MAX        = 16'hFFFF;
    localparam logic        SCAN_MODE_RST   = 1'b0;
    localparam logic [15:0] LONG_TICKS_RST  = 16'd100;
    localparam logic [15:0] WAKE_TICKS_RST  = 16'd4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCAN_MODE  = 2'd0,
        CFG_LONG_TICKS = 2'd1,
        CFG_WAKE_TICKS = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        PRESS_NONE  = 2'd0,
        PRESS_SHORT = 2'd1,
        PRESS_LONG  = 2'd2
    } press_t;

    typedef struct packed {
        logic        scan_mode;
        logic [15:0] long_press_ticks;
        logic [15:0] wake_min_ticks;
    } cfg_t;

    // raw touch codes per slot, unused slots hold code zero
    localparam logic [7:0] CODE_TABLE [TABLE_DEPTH] = '{
        8'd31, 8'd59, 8'd62, 8'd47, 8'd55, 8'd61, 8'd0, 8'd0,
        8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0, 8'd0
    };

    // first matching slot gives index 1..MAP_ENTRIES, else no key
    function automatic logic [7:0] lookup_code(input logic [7:0] code);
        logic [7:0] idx;
        idx = NO_KEY;
        for (int n = MAP_ENTRIES - 1; n >= 0; n--) begin
            if (n < TABLE_DEPTH && CODE_TABLE[n] == code) begin
                idx = 8'(n + 1);
            end
        end
        return idx;
    endfunction

endpackage

### design/kdsl_cfg_regs.sv
// configuration register bank for the key debounce block
`timescale 1ns / 1ps

module kdsl_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [kdsl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kdsl_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output kdsl_pkg::cfg_t                cfg
);
    import kdsl_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_SCAN_MODE:  cfg_next.scan_mode        = cfg_wdata[0];
                CFG_LONG_TICKS: cfg_next.long_press_ticks = cfg_wdata[15:0];
                CFG_WAKE_TICKS: cfg_next.wake_min_ticks   = cfg_wdata[15:0];
                default:        cfg_next = cfg_reg;  // unknown index ignored
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.scan_mode        <= SCAN_MODE_RST;
            cfg_reg.long_press_ticks <= LONG_TICKS_RST;
            cfg_reg.wake_min_ticks   <= WAKE_TICKS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### design/kdsl_press_core.sv
// debounce state and short / long press decision for one scan sample
`timescale 1ns / 1ps

module kdsl_press_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step_en,
    input  logic [7:0]          raw_key,
    input  kdsl_pkg::cfg_t      cfg,
    output kdsl_pkg::press_t    press_event,
    output logic [7:0]          key_index
);
    import kdsl_pkg::*;

    logic [7:0]  prev_sample_reg, prev_sample_next;
    logic [7:0]  stable_key_reg,  stable_key_next;
    logic [15:0] hold_ticks_reg,  hold_ticks_next;
    logic [7:0]  held_index_reg,  held_index_next;
    press_t      event_c;

    always_comb begin
        prev_sample_next = prev_sample_reg;
        stable_key_next  = stable_key_reg;
        hold_ticks_next  = hold_ticks_reg;
        held_index_next  = held_index_reg;
        event_c          = PRESS_NONE;

        if (raw_key != prev_sample_reg) begin
            // sample still bouncing
            prev_sample_next = raw_key;
        end else if (raw_key == NO_KEY) begin
            if (!cfg.scan_mode) begin
                if (stable_key_reg != NO_KEY && hold_ticks_reg < cfg.long_press_ticks) begin
                    event_c = PRESS_SHORT;
                end
                stable_key_next = NO_KEY;
                hold_ticks_next = '0;
            end else if (stable_key_reg != NO_KEY) begin
                // wake mode: release only counts after a long enough hold
                if (hold_ticks_reg > cfg.wake_min_ticks) begin
                    stable_key_next = NO_KEY;
                    hold_ticks_next = '0;
                    event_c         = PRESS_LONG;
                end
            end else begin
                hold_ticks_next = '0;
            end
        end else if (raw_key == stable_key_reg) begin
            if (!cfg.scan_mode && hold_ticks_reg == cfg.long_press_ticks) begin
                hold_ticks_next = '0;
                event_c         = PRESS_LONG;
            end else if (hold_ticks_reg != HOLD_MAX) begin
                hold_ticks_next = hold_ticks_reg + 16'd1;
            end
        end else begin
            // new key, counter deliberately kept
            stable_key_next = raw_key;
            held_index_next = lookup_code(raw_key);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_sample_reg <= NO_KEY;
            stable_key_reg  <= NO_KEY;
            hold_ticks_reg  <= '0;
            held_index_reg  <= NO_KEY;
        end else if (step_en) begin
            prev_sample_reg <= prev_sample_next;
            stable_key_reg  <= stable_key_next;
            hold_ticks_reg  <= hold_ticks_next;
            held_index_reg  <= held_index_next;
        end
    end

    assign press_event = event_c;
    assign key_index   = (event_c != PRESS_NONE) ? held_index_reg : NO_KEY;

endmodule

### design/key_debounce_short_long_press.sv
// top level of the touch key debounce and short / long press detector
//
// usage
// - s_ channel: one raw key code per scan tick in s_tdata, 8'hff means no key
// - m_ channel: one result per request: press event (none, short, long) and
//   the mapped key index 1..12, or 8'hff when unmapped or when no event
// - cfg port: scan mode, long press threshold and wake minimum are set via cfg_wr_en /
//   cfg_index / cfg_wdata; user writes only while the block is idle, not enforced
// - path: an accepted request passes the input register, then decision logic
//   into the result register, from which the receiver takes it
// - throughput: one request per cycle while m_tready is high; the debounce
//   state updates as each request moves from the input register to the result register
// - a stalled m_tready holds the result register; the input register still
//   takes one more request, then s_tready drops until the result is taken
// - reset (aresetn low, synchronous) empties both registers, restores the
//   default configuration and clears the debounce state to no key held
`timescale 1ns / 1ps

module key_debounce_short_long_press (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input requests
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] raw_key
    // results
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata,   // [1:0] press_event, [9:2] key_index
    // configuration writes
    input  logic                            cfg_wr_en,
    input  logic [kdsl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kdsl_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import kdsl_pkg::*;

    cfg_t       cfg;
    press_t     core_event;
    logic [7:0] core_index;

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_key_reg,   in_key_next;

    // result register
    logic       out_valid_reg, out_valid_next;
    press_t     out_event_reg, out_event_next;
    logic [7:0] out_index_reg, out_index_next;

    logic advance;
    logic s_take;

    // move a request on when the result register is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    kdsl_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    kdsl_press_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (advance),
        .raw_key     (in_key_reg),
        .cfg         (cfg),
        .press_event (core_event),
        .key_index   (core_index)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        in_key_next   = in_key_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
            in_key_next   = s_tdata;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_event_next = out_event_reg;
        out_index_next = out_index_reg;
        if (advance) begin
            out_valid_next = 1'b1;
            out_event_next = core_event;
            out_index_next = core_index;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        in_key_reg    <= in_key_next;
        out_event_reg <= out_event_next;
        out_index_reg <= out_index_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_index_reg, out_event_reg};

endmodule
